// File: src/lkv_pkg.sv
// Shared types and constants of the LRU key/value cache.
// No dependencies; every other file imports this package.
package lkv_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned KeyBits        = 16;
  localparam int unsigned ValueBits      = 16;
  localparam int unsigned CfgBits        = 5;
  localparam logic [CfgBits-1:0] CapReset = 5'd16;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef enum logic [1:0] {
    ActNone  = 2'b00,
    ActTouch = 2'b01,
    ActAlloc = 2'b10
  } lkv_act_e;

  typedef struct packed {
    logic                 operation;
    logic [KeyBits-1:0]   item_key;
    logic [ValueBits-1:0] item_value;
  } lkv_req_t;

  typedef struct packed {
    logic                 hit;
    logic [ValueBits-1:0] read_value;
  } lkv_rsp_t;

  // decision of the select logic for the word in flight
  typedef struct packed {
    lkv_act_e act;
    logic     write_key;
    logic     write_value;
    logic     hit;
  } lkv_ctl_t;

  // broadcast to every entry
  typedef struct packed {
    lkv_act_e             act;
    logic                 write_key;
    logic                 write_value;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } lkv_cmd_t;

endpackage

// File: src/lkv_entry.sv
// One cache entry: valid bit, key, value and recency rank, with key compare.
// Depends on lkv_pkg.
module lkv_entry import lkv_pkg::*; #(
  parameter int unsigned RankBits = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lkv_cmd_t             cmd_i,
  input  logic                 sel_i,
  input  logic [RankBits-1:0]  touch_rank_i,
  input  logic [RankBits-1:0]  lru_rank_i,
  output logic                 valid_o,
  output logic                 match_o,
  output logic                 oldest_o,
  output logic [RankBits-1:0]  rank_o,
  output logic [ValueBits-1:0] value_o
);

  logic                 valid_q;
  logic [KeyBits-1:0]   key_q;
  logic [ValueBits-1:0] value_q;
  logic [RankBits-1:0]  rank_q;

  assign valid_o  = valid_q;
  assign match_o  = valid_q && (key_q == cmd_i.key);
  assign oldest_o = valid_q && (rank_q == lru_rank_i);
  assign rank_o   = rank_q;
  assign value_o  = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.act == ActAlloc && sel_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ActTouch: begin
        if (sel_i) begin
          rank_q <= '0;
          if (cmd_i.write_key) key_q <= cmd_i.key;
          if (cmd_i.write_value) value_q <= cmd_i.value;
        end else if (valid_q && rank_q < touch_rank_i) begin
          rank_q <= rank_q + RankBits'(1);
        end
      end
      ActAlloc: begin
        if (sel_i) begin
          rank_q  <= '0;
          key_q   <= cmd_i.key;
          value_q <= cmd_i.value;
        end else if (valid_q) begin
          rank_q <= rank_q + RankBits'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/lkv_select.sv
// Slot selection: hit, LRU victim or lowest free slot, and the action to take.
// Depends on lkv_pkg.
module lkv_select import lkv_pkg::*; #(
  parameter int unsigned Entries  = 16,
  parameter int unsigned RankBits = 4
) (
  input  logic                               item_valid_i,
  input  logic                               operation_i,
  input  logic                               full_i,
  input  logic [Entries-1:0]                 valid_i,
  input  logic [Entries-1:0]                 match_i,
  input  logic [Entries-1:0]                 oldest_i,
  input  logic [Entries-1:0][RankBits-1:0]   rank_i,
  output logic [Entries-1:0]                 sel_o,
  output logic [RankBits-1:0]                touch_rank_o,
  output lkv_ctl_t                           ctl_o
);

  logic [Entries-1:0] free_oh;
  logic               any_match;

  // lowest clear bit of the valid vector
  assign free_oh   = ~valid_i & (valid_i + Entries'(1));
  assign any_match = |match_i;

  always_comb begin
    sel_o             = '0;
    ctl_o.act         = ActNone;
    ctl_o.write_key   = 1'b0;
    ctl_o.write_value = 1'b0;
    ctl_o.hit         = any_match;
    if (item_valid_i) begin
      if (any_match) begin
        sel_o             = match_i;
        ctl_o.act         = ActTouch;
        ctl_o.write_value = (operation_i == OpInsert);
      end else if (operation_i == OpInsert) begin
        if (full_i) begin
          sel_o             = oldest_i;
          ctl_o.act         = ActTouch;
          ctl_o.write_key   = 1'b1;
          ctl_o.write_value = 1'b1;
        end else begin
          sel_o     = free_oh;
          ctl_o.act = ActAlloc;
        end
      end
    end
  end

  // rank of the selected entry; entries ranked below it age by one
  always_comb begin
    touch_rank_o = '0;
    for (int i = 0; i < Entries; i++) begin
      touch_rank_o = touch_rank_o | (rank_i[i] & {RankBits{sel_o[i]}});
    end
  end

endmodule

// File: src/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg, lkv_entry and lkv_select.
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+-------------------------------
//  request   | start, busy, req_i           | word taken when start && !busy
//  result    | done_o, rsp_o                | one-cycle strobe, no back-pressure
//  config    | cfg_we_i, cfg_wdata_i        | capacity written when cfg_we_i
//
// Throughput is one word per cycle: busy is tied low. A request word is
// registered at acceptance, and in the following cycle the parallel key
// compare across the entry row, the slot select and the rank update run
// between that register and the entry/result registers. A lookup result
// shows on done_o from the result register; inserts give none.
// Reset clears the valid bits, the occupancy count and sets the capacity
// to 16; keys, values and ranks are not reset. The receiver cannot stall.
module lru_key_value_cache_unit import lkv_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DefaultEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lkv_req_t           req_i,
  output logic               done_o,
  output lkv_rsp_t           rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i
);

  localparam int unsigned RankBits = $clog2(MAX_ENTRIES);
  localparam int unsigned OccBits  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpBits  = (OccBits > CfgBits) ? OccBits : CfgBits;

  // input register
  logic     item_v_q;
  lkv_req_t req_q;
  // result register
  logic     done_q;
  lkv_rsp_t rsp_q;
  // capacity and fill count
  logic [CfgBits-1:0] cap_q;
  logic [OccBits-1:0] occ_q;

  logic [OccBits-1:0] occ_m1;
  logic [RankBits-1:0] lru_rank;
  logic [CmpBits-1:0] cap_ext, occ_ext, max_ext, eff_cap;
  logic               full;

  logic [MAX_ENTRIES-1:0]                valid_vec, match_vec, oldest_vec, sel_vec;
  logic [MAX_ENTRIES-1:0][RankBits-1:0]  rank_vec;
  logic [MAX_ENTRIES-1:0][ValueBits-1:0] value_vec;
  logic [RankBits-1:0]                   touch_rank;
  logic [ValueBits-1:0]                  hit_value;
  lkv_ctl_t                              ctl;
  lkv_cmd_t                              cmd;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      done_q   <= 1'b0;
      cap_q    <= CapReset;
      occ_q    <= '0;
    end else begin
      item_v_q <= start && !busy;
      done_q   <= item_v_q && (req_q.operation == OpLookup);
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (ctl.act == ActAlloc) occ_q <= occ_q + OccBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    rsp_q.hit        <= ctl.hit;
    rsp_q.read_value <= hit_value;
  end

  // capacity 0 acts as 1; above the entry count saturates
  assign cap_ext = CmpBits'(cap_q);
  assign occ_ext = CmpBits'(occ_q);
  assign max_ext = CmpBits'(MAX_ENTRIES);
  always_comb begin
    if (cap_ext == '0)          eff_cap = CmpBits'(1);
    else if (cap_ext > max_ext) eff_cap = max_ext;
    else                        eff_cap = cap_ext;
  end
  assign full = (occ_ext >= eff_cap);

  // ranks of valid entries are a permutation of 0..occ-1, so the LRU entry
  // is the one ranked occ-1
  assign occ_m1   = occ_q - OccBits'(1);
  assign lru_rank = occ_m1[RankBits-1:0];

  assign cmd.act         = ctl.act;
  assign cmd.write_key   = ctl.write_key;
  assign cmd.write_value = ctl.write_value;
  assign cmd.key         = req_q.item_key;
  assign cmd.value       = req_q.item_value;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_entry
    lkv_entry #(
      .RankBits (RankBits)
    ) u_entry (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_i        (sel_vec[g]),
      .touch_rank_i (touch_rank),
      .lru_rank_i   (lru_rank),
      .valid_o      (valid_vec[g]),
      .match_o      (match_vec[g]),
      .oldest_o     (oldest_vec[g]),
      .rank_o       (rank_vec[g]),
      .value_o      (value_vec[g])
    );
  end

  lkv_select #(
    .Entries  (MAX_ENTRIES),
    .RankBits (RankBits)
  ) u_select (
    .item_valid_i (item_v_q),
    .operation_i  (req_q.operation),
    .full_i       (full),
    .valid_i      (valid_vec),
    .match_i      (match_vec),
    .oldest_i     (oldest_vec),
    .rank_i       (rank_vec),
    .sel_o        (sel_vec),
    .touch_rank_o (touch_rank),
    .ctl_o        (ctl)
  );

  // at most one entry matches; a miss reads zero
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_value = hit_value | (value_vec[i] & {ValueBits{match_vec[i]}});
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: src/lkv_checker.sv
// Port-level checks of the LRU key/value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_unit.
module lkv_checker import lkv_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input lkv_req_t req_i,
  input logic     done_o,
  input lkv_rsp_t rsp_o
);

  logic acc_lookup, acc_insert;
  assign acc_lookup = start && !busy && (req_i.operation == OpLookup);
  assign acc_insert = start && !busy && (req_i.operation == OpInsert);

  // one result per lookup, through the input and result registers, and nothing else
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 1) && $past(rst_ni, 2) |-> done_o == $past(acc_lookup, 2))
    else $error("result strobe does not follow lookups");

  // a miss reports zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.hit |-> rsp_o.read_value == '0)
    else $error("miss with nonzero value");

  // lookup right behind an insert of the same key sees the new value
  a_insert_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
    $past(acc_insert, 3) && $past(acc_lookup, 2) &&
    ($past(req_i.item_key, 3) == $past(req_i.item_key, 2))
    |-> done_o && rsp_o.hit && (rsp_o.read_value == $past(req_i.item_value, 3)))
    else $error("back-to-back insert then lookup lost the word");

  // a lookup repeated right after a hit still hits with the same value
  a_repeat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 1) && done_o && rsp_o.hit && $past(acc_lookup, 2) &&
    $past(acc_lookup, 1) && ($past(req_i.item_key, 2) == $past(req_i.item_key, 1))
    |=> done_o && rsp_o.hit && $stable(rsp_o.read_value))
    else $error("repeated lookup changed result");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: tb/lru_key_value_cache_unit_tb.sv
// Self-checking testbench for the LRU key/value cache top level.
// Depends on lkv_pkg and lru_key_value_cache_unit; keeps its own mirror of the store.
module lru_key_value_cache_unit_tb import lkv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots      = DefaultEntries;
  localparam int PoolSize   = 24;
  localparam int PhaseWords = 65;
  localparam int SettleCyc  = 4;    // accept -> result through the input and result registers; slack on top
  localparam int DrainLimit = 100;  // cycles allowed for owed lookups to come back

  // clock, reset and DUT ports; every input is known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  lkv_req_t           req         = '0;
  logic               done;
  lkv_rsp_t           rsp;
  logic               cfg_we_i    = 1'b0;
  logic [CfgBits-1:0] cfg_wdata_i = '0;

  always #5 clk_i = ~clk_i;

  lru_key_value_cache_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the store. Updated when a word is taken by the DUT, so its order
  // is the DUT's order. Capacity changes only while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic                 slot_valid [Slots];
  logic [KeyBits-1:0]   slot_key   [Slots];
  logic [ValueBits-1:0] slot_value [Slots];
  int unsigned          slot_age   [Slots];  // 0 = most recent
  int unsigned          fill_count;
  logic [CfgBits-1:0]   capacity_reg;

  lkv_rsp_t lookups_owed [$];   // lookup results still to come, oldest first
  lkv_req_t pending_words [$];  // words waiting for the driver
  int       words_queued;
  int       words_taken;
  int       mismatches;

  logic [KeyBits-1:0] key_pool [PoolSize];

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_age[i]   = 0;
    end
    fill_count   = 0;
    capacity_reg = CapReset;
    words_queued = 0;
    words_taken  = 0;
    mismatches   = 0;
  end

  function automatic int find_key_slot(logic [KeyBits-1:0] k);
    for (int i = 0; i < Slots; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // entries younger than s age by one, s becomes the most recent
  function automatic void make_recent(int s);
    for (int i = 0; i < Slots; i++)
      if (slot_valid[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic int unsigned usable_capacity();
    int unsigned c;
    c = capacity_reg;
    if (c == 0) c = 1;          // zero behaves as one
    if (c > Slots) c = Slots;   // saturate at the number of slots
    return c;
  endfunction

  // Apply one taken word to the mirror; a lookup queues its expected result.
  task automatic predict_cache_word(lkv_req_t w);
    int       s;
    int       victim;
    lkv_rsp_t r;
    s = find_key_slot(w.item_key);
    if (w.operation == OpLookup) begin
      r.hit        = (s >= 0);
      r.read_value = (s >= 0) ? slot_value[s] : '0;  // miss reads as zero
      if (s >= 0) make_recent(s);
      lookups_owed.push_back(r);
    end else if (s >= 0) begin
      // key present: overwrite value, refresh recency
      slot_value[s] = w.item_value;
      make_recent(s);
    end else if (fill_count >= usable_capacity()) begin
      // full, or capacity lowered below occupancy: reuse the oldest slot
      victim = -1;
      for (int i = 0; i < Slots; i++)
        if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_key[victim]   = w.item_key;
        slot_value[victim] = w.item_value;
        make_recent(victim);
      end
    end else begin
      // room left: lowest free slot, everyone else ages
      victim = -1;
      for (int i = Slots - 1; i >= 0; i--)
        if (!slot_valid[i]) victim = i;
      for (int i = 0; i < Slots; i++)
        if (slot_valid[i]) slot_age[i]++;
      slot_valid[victim] = 1'b1;
      slot_key[victim]   = w.item_key;
      slot_value[victim] = w.item_value;
      slot_age[victim]   = 0;
      fill_count++;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes words from pending_words in bursts with random gaps.
  // A word counts as taken at the edge where start is high and busy low.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_cache_word(req);
        words_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          start <= 1'b1;
          req   <= pending_words.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: the result strobe cannot be held off, so every done is compared
  // against the oldest owed lookup on the edge that ends it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lkv_rsp_t want;
    if (rst_ni && done) begin
      if (lookups_owed.size() == 0) begin
        report_mismatch($sformatf("result word with no lookup owed (hit=%0b value=%h)",
                                  rsp.hit, rsp.read_value));
      end else begin
        want = lookups_owed.pop_front();
        if (rsp.hit !== want.hit)
          report_mismatch($sformatf("hit: got %b, want %b", rsp.hit, want.hit));
        if (rsp.read_value !== want.read_value)
          report_mismatch($sformatf("read_value: got %h, want %h",
                                    rsp.read_value, want.read_value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic op, logic [KeyBits-1:0] k, logic [ValueBits-1:0] v);
    lkv_req_t w;
    w.operation  = op;
    w.item_key   = k;
    w.item_value = v;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // mostly pool keys so hits, updates and evictions happen; some fresh keys
  task automatic queue_random_words(int count);
    logic [KeyBits-1:0] k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) k = KeyBits'($urandom);
      else                           k = key_pool[$urandom_range(0, PoolSize - 1)];
      queue_word(($urandom_range(0, 99) < 55) ? OpLookup : OpInsert, k,
                 ValueBits'($urandom));
    end
  endtask

  // Sender holds off until every word is taken and every lookup answered,
  // then lets inserts still in the pipe finish.
  task automatic settle();
    int waited;
    waited = 0;
    while (words_taken != words_queued) @(posedge clk_i);
    while (lookups_owed.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CfgBits-1:0] c);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= c;
    capacity_reg  = c;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
  endtask

  logic [CfgBits-1:0] phase_caps [8];

  initial begin
    phase_caps = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd16, 5'd5, 5'd9, 5'd0};
    phase_caps[7] = CfgBits'($urandom_range(0, 31));
    for (int i = 0; i < PoolSize; i++) key_pool[i] = KeyBits'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset capacity, key/value extremes, update, fill and evict.
    queue_word(OpLookup, '0, '1);            // lookup on an empty store
    queue_word(OpInsert, '0, '1);
    queue_word(OpInsert, '1, '0);
    queue_word(OpLookup, '0, '0);
    queue_word(OpLookup, '1, '1);
    queue_word(OpInsert, '1, 16'h5a3c);      // update of a held key
    queue_word(OpLookup, '1, '0);
    for (int i = 1; i <= 14; i++)            // fill all sixteen slots
      queue_word(OpInsert, KeyBits'(i), ValueBits'(16'h1000 + i));
    queue_word(OpInsert, 16'h8001, 16'hc3a5); // full: evicts key 0, the oldest
    queue_word(OpLookup, 16'h0001, '0);       // still held, so a hit
    queue_word(OpLookup, '0, '0);             // evicted, so a miss
    settle();

    // Random phases, one capacity each; the first drops capacity far below
    // the occupancy left by the directed part.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      queue_random_words(PhaseWords);
      settle();
    end

    if (lookups_owed.size() != 0)
      report_mismatch($sformatf("%0d lookup results never arrived", lookups_owed.size()));

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop; a correct run ends well under a tenth of this
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
